FILE: rtl/jddm_pkg.sv
`default_nettype none
package jddm_pkg;

  localparam int unsigned PULSE_W    = 16;
  localparam int unsigned HELD_W     = 17;
  localparam int unsigned FAILSAFE_W = 12;
  localparam int unsigned DEADBAND_W = 11;
  localparam int unsigned OFFSET_W   = 8;
  localparam int unsigned THR_W      = 8;
  localparam int unsigned LEVEL_W    = 11;
  localparam int unsigned PINS_W     = 4;
  localparam int unsigned COORD_W    = 13;
  localparam int unsigned DIFF_W     = 11;
  localparam int unsigned PROD_W     = 29;
  localparam int unsigned RECIP_W    = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // input span 800..2200 maps onto -1550..1550
  localparam logic [HELD_W-1:0]         IN_LO   = 17'd800;
  localparam logic [HELD_W-1:0]         IN_HI   = 17'd2200;
  localparam logic signed [COORD_W-1:0] OUT_LIM = 13'sd1550;
  localparam logic [LEVEL_W-1:0]        MAX_LEVEL = 11'd1550;

  // x*31/14 = ((x*31) >> 1) / 7, and /7 as multiply by ceil(2^17/7) then shift
  localparam logic [RECIP_W-1:0] RECIP_7     = 15'd18725;
  localparam int unsigned        RECIP_SHIFT = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAILSAFE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_THR   = 3'd5;

  localparam logic [PULSE_W-1:0]    RST_LOW_LIMIT  = 16'd900;
  localparam logic [PULSE_W-1:0]    RST_HIGH_LIMIT = 16'd2100;
  localparam logic [FAILSAFE_W-1:0] RST_FAILSAFE   = 12'd1500;
  localparam logic [DEADBAND_W-1:0] RST_DEADBAND   = 11'd50;
  localparam logic [OFFSET_W-1:0]   RST_OFFSET     = 8'd15;
  localparam logic [THR_W-1:0]      RST_FLIP_THR   = 8'd5;

  // logical bridge enables
  localparam logic [PINS_W-1:0] LOGIC_LF = 4'b0001;
  localparam logic [PINS_W-1:0] LOGIC_LR = 4'b0010;
  localparam logic [PINS_W-1:0] LOGIC_RF = 4'b0100;
  localparam logic [PINS_W-1:0] LOGIC_RR = 4'b1000;

  typedef struct packed {
    logic [PULSE_W-1:0]    low_limit;
    logic [PULSE_W-1:0]    high_limit;
    logic [FAILSAFE_W-1:0] failsafe;
    logic [DEADBAND_W-1:0] deadband;
    logic [OFFSET_W-1:0]   offset;
    logic [THR_W-1:0]      flip_thr;
  } cfg_t;

  typedef struct packed {
    logic              clamp_lo;
    logic              clamp_hi;
    logic [PROD_W-1:0] prod;
  } scaled_t;

  function automatic logic [DIFF_W-1:0] mag_lvl(input logic signed [COORD_W-1:0] v);
    logic signed [COORD_W-1:0] n;
    n = -v;
    return v[COORD_W-1] ? n[DIFF_W-1:0] : v[DIFF_W-1:0];
  endfunction

  function automatic logic [PINS_W-1:0] to_pins(input logic [PINS_W-1:0] lg,
                                                input logic flipped);
    logic [PINS_W-1:0] p;
    p = '0;
    if (!flipped) begin
      p[0] = |(lg & LOGIC_LR);
      p[1] = |(lg & LOGIC_LF);
      p[2] = |(lg & LOGIC_RR);
      p[3] = |(lg & LOGIC_RF);
    end else begin
      p[0] = |(lg & LOGIC_RF);
      p[1] = |(lg & LOGIC_RR);
      p[2] = |(lg & LOGIC_LF);
      p[3] = |(lg & LOGIC_LR);
    end
    return p;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/joystick_differential_drive_mixer_core.sv
// channel  direction  handshake                 payload
// in       sink       in_valid_i / in_ready_o   raw_pulse_a_i raw_pulse_b_i edge_seen_i tilt_accel_i
// out      source     out_valid_o / out_ready_i left_duty_o right_duty_o bridge_pins_o inverted_mode_o
// cfg      sink       cfg_we_i                  cfg_idx_i cfg_wdata_i
//
// one beat per cycle sustained while the output is not stalled; each beat passes the stages below in order
// stages: input register, pulse hold and tilt state, scaling multiplier, mixing
// held pulses and tilt state update once per beat taken into the hold stage
// a stalled output holds each stage that is full; empty stages still take beats
// reset is asynchronous active low and loads the register defaults
`default_nettype none
module joystick_differential_drive_mixer_core #(
  parameter int unsigned COUNT_BITS = 8
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [jddm_pkg::PULSE_W-1:0]         raw_pulse_a_i,
  input  wire logic [jddm_pkg::PULSE_W-1:0]         raw_pulse_b_i,
  input  wire logic                                 edge_seen_i,
  input  wire logic signed [jddm_pkg::PULSE_W-1:0]  tilt_accel_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [jddm_pkg::LEVEL_W-1:0]              left_duty_o,
  output logic [jddm_pkg::LEVEL_W-1:0]              right_duty_o,
  output logic [jddm_pkg::PINS_W-1:0]               bridge_pins_o,
  output logic                                      inverted_mode_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [jddm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [jddm_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  jddm_pkg::cfg_t cfg_q, cfg_d;

  logic v0_q, v0_d, v1_q, v1_d, v2_q, v2_d, v3_q, v3_d;
  logic rdy1, rdy2, rdy3, en1, en2, en3, in_acc;

  logic [jddm_pkg::PULSE_W-1:0]        raw_a_q, raw_b_q;
  logic                                edge_q;
  logic signed [jddm_pkg::PULSE_W-1:0] tilt_q;
  logic                                flip2_q, flip3_q;

  logic [jddm_pkg::HELD_W-1:0]  held_a, held_b;
  logic                         flipped;
  jddm_pkg::scaled_t            sa, sb;
  logic [jddm_pkg::LEVEL_W-1:0] left_lvl, right_lvl;
  logic [jddm_pkg::PINS_W-1:0]  pins;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        jddm_pkg::CFG_LOW_LIMIT:  cfg_d.low_limit  = cfg_wdata_i;
        jddm_pkg::CFG_HIGH_LIMIT: cfg_d.high_limit = cfg_wdata_i;
        jddm_pkg::CFG_FAILSAFE:   cfg_d.failsafe   = cfg_wdata_i[jddm_pkg::FAILSAFE_W-1:0];
        jddm_pkg::CFG_DEADBAND:   cfg_d.deadband   = cfg_wdata_i[jddm_pkg::DEADBAND_W-1:0];
        jddm_pkg::CFG_OFFSET:     cfg_d.offset     = cfg_wdata_i[jddm_pkg::OFFSET_W-1:0];
        jddm_pkg::CFG_FLIP_THR:   cfg_d.flip_thr   = cfg_wdata_i[jddm_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_limit  <= jddm_pkg::RST_LOW_LIMIT;
      cfg_q.high_limit <= jddm_pkg::RST_HIGH_LIMIT;
      cfg_q.failsafe   <= jddm_pkg::RST_FAILSAFE;
      cfg_q.deadband   <= jddm_pkg::RST_DEADBAND;
      cfg_q.offset     <= jddm_pkg::RST_OFFSET;
      cfg_q.flip_thr   <= jddm_pkg::RST_FLIP_THR;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // pipeline flow
  always_comb begin
    rdy3 = !v3_q || out_ready_i;
    en3  = v2_q && rdy3;
    rdy2 = !v2_q || rdy3;
    en2  = v1_q && rdy2;
    rdy1 = !v1_q || rdy2;
    en1  = v0_q && rdy1;
    in_ready_o = !v0_q || rdy1;
    in_acc = in_valid_i && in_ready_o;
    v0_d = in_acc ? 1'b1 : (en1 ? 1'b0 : v0_q);
    v1_d = en1 ? 1'b1 : (en2 ? 1'b0 : v1_q);
    v2_d = en2 ? 1'b1 : (en3 ? 1'b0 : v2_q);
    v3_d = en3 ? 1'b1 : ((v3_q && out_ready_i) ? 1'b0 : v3_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      raw_a_q <= raw_pulse_a_i;
      raw_b_q <= raw_pulse_b_i;
      edge_q  <= edge_seen_i;
      tilt_q  <= tilt_accel_i;
    end
    if (en2) flip2_q <= flipped;
    if (en3) flip3_q <= flip2_q;
  end

  jddm_capture #(
    .COUNT_BITS(COUNT_BITS)
  ) u_capture (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en1),
    .cfg_i     (cfg_q),
    .raw_a_i   (raw_a_q),
    .raw_b_i   (raw_b_q),
    .edge_i    (edge_q),
    .tilt_i    (tilt_q),
    .held_a_o  (held_a),
    .held_b_o  (held_b),
    .flipped_o (flipped)
  );

  jddm_scale u_scale_a (
    .clk_i    (clk_i),
    .en_i     (en2),
    .pulse_i  (held_a),
    .scaled_o (sa)
  );

  jddm_scale u_scale_b (
    .clk_i    (clk_i),
    .en_i     (en2),
    .pulse_i  (held_b),
    .scaled_o (sb)
  );

  jddm_mix u_mix (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en3),
    .sa_i          (sa),
    .sb_i          (sb),
    .flipped_i     (flip2_q),
    .deadband_i    (cfg_q.deadband),
    .left_level_o  (left_lvl),
    .right_level_o (right_lvl),
    .pins_o        (pins)
  );

  assign out_valid_o     = v3_q;
  assign left_duty_o     = flip3_q ? right_lvl : left_lvl;
  assign right_duty_o    = flip3_q ? left_lvl : right_lvl;
  assign bridge_pins_o   = pins;
  assign inverted_mode_o = flip3_q;

`ifndef SYNTH
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v0_q && v1_q && v2_q && v3_q))
    else $error("input blocked with a free stage");

  a_pins_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pins == '0) || ($countones(pins) == 2))
    else $error("bridge pattern not zero or a pair");

  a_no_shoot_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pins[0] && pins[1]) && !(pins[2] && pins[3]))
    else $error("both directions enabled on one motor");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_lvl <= jddm_pkg::MAX_LEVEL) && (right_lvl <= jddm_pkg::MAX_LEVEL))
    else $error("drive level above full scale");
`endif

endmodule
`default_nettype wire

FILE: rtl/jddm_capture.sv
`default_nettype none
module jddm_capture #(
  parameter int unsigned COUNT_BITS = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire jddm_pkg::cfg_t                    cfg_i,
  input  wire logic [jddm_pkg::PULSE_W-1:0]      raw_a_i,
  input  wire logic [jddm_pkg::PULSE_W-1:0]      raw_b_i,
  input  wire logic                              edge_i,
  input  wire logic signed [jddm_pkg::PULSE_W-1:0] tilt_i,
  output logic [jddm_pkg::HELD_W-1:0]            held_a_o,
  output logic [jddm_pkg::HELD_W-1:0]            held_b_o,
  output logic                                   flipped_o
);

  localparam int unsigned CmpW = (COUNT_BITS > jddm_pkg::THR_W) ? COUNT_BITS
                                                                : jddm_pkg::THR_W;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [jddm_pkg::HELD_W-1:0] held_a_q, held_a_d, held_b_q, held_b_d;
  logic [jddm_pkg::HELD_W-1:0] cand_a, cand_b, off_ext, low_ext, high_ext, fs_ext;
  logic [COUNT_BITS-1:0]       neg_q, neg_d, pos_q, pos_d, neg_n, pos_n;
  logic                        flipped_q, flipped_d;
  logic                        fail, tilt_neg, tilt_pos, set_flip, clr_flip;

  always_comb begin
    off_ext  = jddm_pkg::HELD_W'(cfg_i.offset);
    low_ext  = jddm_pkg::HELD_W'(cfg_i.low_limit);
    high_ext = jddm_pkg::HELD_W'(cfg_i.high_limit);
    fs_ext   = jddm_pkg::HELD_W'(cfg_i.failsafe);
    cand_a = edge_i ? jddm_pkg::HELD_W'(raw_a_i) + off_ext : held_a_q;
    cand_b = edge_i ? jddm_pkg::HELD_W'(raw_b_i) + off_ext : held_b_q;
    fail = (cand_a < low_ext) || (cand_b < low_ext) ||
           (cand_a > high_ext) || (cand_b > high_ext);
    held_a_d = fail ? fs_ext : cand_a;
    held_b_d = fail ? fs_ext : cand_b;

    tilt_neg = tilt_i[jddm_pkg::PULSE_W-1];
    tilt_pos = !tilt_neg && (tilt_i != '0);
    neg_n = neg_q;
    pos_n = pos_q;
    if (tilt_neg) begin
      if (neg_q != CountMax) neg_n = neg_q + COUNT_BITS'(1);
    end else begin
      if (pos_q != CountMax) pos_n = pos_q + COUNT_BITS'(1);
    end
    set_flip = tilt_neg && (CmpW'(neg_n) > CmpW'(cfg_i.flip_thr));
    clr_flip = tilt_pos && (CmpW'(pos_n) > CmpW'(cfg_i.flip_thr));
    neg_d = neg_n;
    pos_d = pos_n;
    flipped_d = flipped_q;
    if (set_flip || clr_flip) begin
      neg_d = '0;
      pos_d = '0;
      flipped_d = set_flip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_a_q  <= '0;
      held_b_q  <= '0;
      neg_q     <= '0;
      pos_q     <= '0;
      flipped_q <= 1'b0;
    end else if (en_i) begin
      held_a_q  <= held_a_d;
      held_b_q  <= held_b_d;
      neg_q     <= neg_d;
      pos_q     <= pos_d;
      flipped_q <= flipped_d;
    end
  end

  assign held_a_o  = held_a_q;
  assign held_b_o  = held_b_q;
  assign flipped_o = flipped_q;

endmodule
`default_nettype wire

FILE: rtl/jddm_scale.sv
`default_nettype none
module jddm_scale (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic [jddm_pkg::HELD_W-1:0]  pulse_i,
  output jddm_pkg::scaled_t                 scaled_o
);

  logic [jddm_pkg::HELD_W-1:0]  span;
  logic [jddm_pkg::DIFF_W-1:0]  d;
  logic [15:0]                  n;
  logic [14:0]                  m;
  jddm_pkg::scaled_t            scaled_d, scaled_q;

  always_comb begin
    span = pulse_i - jddm_pkg::IN_LO;
    d    = span[jddm_pkg::DIFF_W-1:0];
    n    = {d, 5'b0} - 16'(d);
    m    = n[15:1];
    scaled_d.clamp_lo = pulse_i < jddm_pkg::IN_LO;
    scaled_d.clamp_hi = pulse_i >= jddm_pkg::IN_HI;
    scaled_d.prod     = jddm_pkg::PROD_W'(m) * jddm_pkg::PROD_W'(jddm_pkg::RECIP_7);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      scaled_q <= scaled_d;
    end
  end

  assign scaled_o = scaled_q;

endmodule
`default_nettype wire

FILE: rtl/jddm_mix.sv
`default_nettype none
module jddm_mix (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             en_i,
  input  wire jddm_pkg::scaled_t                sa_i,
  input  wire jddm_pkg::scaled_t                sb_i,
  input  wire logic                             flipped_i,
  input  wire logic [jddm_pkg::DEADBAND_W-1:0]  deadband_i,
  output logic [jddm_pkg::LEVEL_W-1:0]          left_level_o,
  output logic [jddm_pkg::LEVEL_W-1:0]          right_level_o,
  output logic [jddm_pkg::PINS_W-1:0]           pins_o
);

  localparam int unsigned QW = jddm_pkg::PROD_W - jddm_pkg::RECIP_SHIFT;

  logic signed [jddm_pkg::COORD_W-1:0] x, y, sum, dif;
  logic [jddm_pkg::LEVEL_W-1:0]        left_q, left_d, right_q, right_d;
  logic [jddm_pkg::PINS_W-1:0]         pins_q, pins_d, lg;
  logic [jddm_pkg::DIFF_W-1:0]         mx, my, msum, mdif;
  logic                                hit;

  function automatic logic signed [jddm_pkg::COORD_W-1:0] coord(
      input jddm_pkg::scaled_t s);
    logic [QW-1:0] q;
    q = s.prod[jddm_pkg::PROD_W-1:jddm_pkg::RECIP_SHIFT];
    if (s.clamp_lo) return -jddm_pkg::OUT_LIM;
    if (s.clamp_hi) return jddm_pkg::OUT_LIM;
    return $signed(jddm_pkg::COORD_W'(q)) - jddm_pkg::OUT_LIM;
  endfunction

  always_comb begin
    x    = coord(sa_i);
    y    = coord(sb_i);
    sum  = y + x;
    dif  = y - x;
    mx   = jddm_pkg::mag_lvl(x);
    my   = jddm_pkg::mag_lvl(y);
    msum = jddm_pkg::mag_lvl(sum);
    mdif = jddm_pkg::mag_lvl(dif);
    hit  = 1'b1;
    left_d  = left_q;
    right_d = right_q;
    lg      = '0;
    if ((mx < deadband_i) && (my < deadband_i)) begin
      hit = 1'b0;
      left_d  = '0;
      right_d = '0;
    end else if (x < 0 && y < 0) begin
      if (x >= y) begin
        left_d = mdif; right_d = my; lg = jddm_pkg::LOGIC_RR | jddm_pkg::LOGIC_LR;
      end else begin
        left_d = mdif; right_d = mdif; lg = jddm_pkg::LOGIC_LR | jddm_pkg::LOGIC_RF;
      end
    end else if (x < 0 && y > 0) begin
      if (sum >= 0) begin
        left_d = msum; right_d = my; lg = jddm_pkg::LOGIC_RF | jddm_pkg::LOGIC_LF;
      end else begin
        left_d = msum; right_d = mx; lg = jddm_pkg::LOGIC_LR | jddm_pkg::LOGIC_RF;
      end
    end else if (x > 0 && y < 0) begin
      if (sum <= 0) begin
        left_d = my; right_d = msum; lg = jddm_pkg::LOGIC_RR | jddm_pkg::LOGIC_LR;
      end else begin
        left_d = msum; right_d = msum; lg = jddm_pkg::LOGIC_LF | jddm_pkg::LOGIC_RR;
      end
    end else if (x > 0 && y > 0) begin
      if (y >= x) begin
        left_d = my; right_d = mdif; lg = jddm_pkg::LOGIC_RF | jddm_pkg::LOGIC_LF;
      end else begin
        left_d = mx; right_d = mdif; lg = jddm_pkg::LOGIC_LF | jddm_pkg::LOGIC_RR;
      end
    end else begin
      hit = 1'b0;
    end
    if (hit) begin
      pins_d = jddm_pkg::to_pins(lg, flipped_i);
    end else if ((mx < deadband_i) && (my < deadband_i)) begin
      pins_d = '0;
    end else begin
      pins_d = pins_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      right_q <= '0;
      pins_q  <= '0;
    end else if (en_i) begin
      left_q  <= left_d;
      right_q <= right_d;
      pins_q  <= pins_d;
    end
  end

  assign left_level_o  = left_q;
  assign right_level_o = right_q;
  assign pins_o        = pins_q;

endmodule
`default_nettype wire
